FILE: rtl/core/fpss_pkg.sv
package fpss_pkg;

  // Default sizes of the design
  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_SAMPLE_BITS = 32;

  // Register port geometry
  localparam int CFG_DIM_BITS  = 13;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [CFG_DIM_BITS-1:0] DIM_RESET = 13'd4096;

  // Register index, taken from the word address bit
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Last border index for a size register: zero counts as one,
  // oversize clamps to the maximum
  function automatic int unsigned dim_last(input logic [CFG_DIM_BITS-1:0] raw,
                                           input int unsigned maxv);
    int unsigned v;
    v = 32'(raw);
    if (v == 0) begin
      v = 1;
    end else if (v > maxv) begin
      v = maxv;
    end
    return v + 1;
  endfunction

endpackage

FILE: rtl/core/five_point_stencil_stream.sv
// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+-------------------------------------
// in_      | in  | in_valid / in_ready   | in_sample_in (raster, border incl.)
// out_     | out | out_valid / out_ready | out_sample_out, out_frame_last
// config   | in  | APB psel/penable      | paddr, pwdata, prdata (width, height)
//
// One request per cycle when the output side keeps up and no register write
// is under way; an item's result appears in the output register the cycle after it is taken.
// The rate is set by the line-store pass: every request reads the upper store
// once and the middle store twice (center, east) for the next column.
// After reset and after any register write the window is primed before the
// first request is taken. The line stores need no clearing.
// A stalled result holds in the output register and blocks new requests.
module five_point_stencil_stream #(
  parameter int MAX_WIDTH   = fpss_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = fpss_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = fpss_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  output logic                                 out_frame_last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fpss_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [fpss_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [fpss_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);
  import fpss_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH + 2;
  localparam int AW         = $clog2(MAX_WIDTH + 2);
  localparam int RW         = $clog2(MAX_HEIGHT + 2);
  localparam int SB         = SAMPLE_BITS;
  localparam int SUM_BITS   = SAMPLE_BITS + 3;

  localparam logic [AW-1:0] W_LAST_RST = AW'(dim_last(DIM_RESET, MAX_WIDTH));
  localparam logic [RW-1:0] H_LAST_RST = RW'(dim_last(DIM_RESET, MAX_HEIGHT));

  // Register file
  logic [CFG_DIM_BITS-1:0] frame_width_r;
  logic [CFG_DIM_BITS-1:0] frame_height_r;
  logic [AW-1:0]           w_last_r;
  logic [RW-1:0]           h_last_r;
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;

  // Position counters and window
  logic [AW-1:0]           col_r;
  logic [RW-1:0]           row_r;
  logic [AW-1:0]           col_nxt;
  logic [RW-1:0]           row_nxt;
  logic                    prime_ok_r;
  logic signed [SB-1:0]    west_r;

  // Line stores
  logic signed [SB-1:0]    upper_mem [LINE_DEPTH];
  logic signed [SB-1:0]    middle_mem [LINE_DEPTH];
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           east_addr;
  logic signed [SB-1:0]    north_rd_r;
  logic signed [SB-1:0]    center_rd_r;
  logic signed [SB-1:0]    east_rd_r;

  // Datapath
  logic                    in_take;
  logic                    has_result;
  logic                    last_now;
  logic signed [SUM_BITS-1:0] sum;
  logic [SB:0]             quo;
  logic signed [SB-1:0]    sat;

  logic                    out_valid_r;
  logic signed [SB-1:0]    out_sample_r;
  logic                    out_last_r;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_BITS'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_BITS'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_RESET;
      frame_height_r <= DIM_RESET;
      w_last_r       <= W_LAST_RST;
      h_last_r       <= H_LAST_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH: begin
          frame_width_r <= pwdata[CFG_DIM_BITS-1:0];
          w_last_r      <= AW'(dim_last(pwdata[CFG_DIM_BITS-1:0], MAX_WIDTH));
        end
        REG_FRAME_HEIGHT: begin
          frame_height_r <= pwdata[CFG_DIM_BITS-1:0];
          h_last_r       <= RW'(dim_last(pwdata[CFG_DIM_BITS-1:0], MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign in_ready = prime_ok_r & ~cfg_wr & (~out_valid_r | out_ready);
  assign in_take  = in_valid & in_ready;

  // ---------------- counters ----------------
  always_comb begin
    if (col_r == w_last_r) begin
      col_nxt = '0;
      row_nxt = (row_r == h_last_r) ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + AW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      prime_ok_r <= 1'b0;
    end else begin
      // window data lags the counters through the read registers after a reposition
      prime_ok_r <= ~cfg_wr;
      if (cfg_wr) begin
        col_r <= '0;
        row_r <= '0;
      end else if (in_take) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // ---------------- line stores ----------------
  // Look ahead: read the column that the next request will use
  assign rd_addr   = in_take ? col_nxt : col_r;
  assign east_addr = (rd_addr == w_last_r) ? '0 : rd_addr + AW'(1);

  always_ff @(posedge clk) begin
    if (in_take) begin
      upper_mem[col_r]  <= center_rd_r;
      middle_mem[col_r] <= in_sample_in;
    end
    north_rd_r  <= upper_mem[rd_addr];
    center_rd_r <= middle_mem[rd_addr];
    east_rd_r   <= middle_mem[east_addr];
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      west_r <= center_rd_r;
    end
  end

  // ---------------- stencil ----------------
  assign has_result = (row_r >= RW'(2)) && (col_r != '0) && (col_r != w_last_r);
  assign last_now   = (row_r == h_last_r) && (col_r == w_last_r - AW'(1));

  always_comb begin
    sum = (SUM_BITS'(center_rd_r) <<< 1) + SUM_BITS'(center_rd_r)
        + SUM_BITS'(north_rd_r) + SUM_BITS'(in_sample_in)
        + SUM_BITS'(west_r) + SUM_BITS'(east_rd_r);
    // floor divide by four, then clamp to the sample range
    quo = sum[SB+2:2];
    if (quo[SB] != quo[SB-1]) begin
      sat = quo[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end else begin
      sat = quo[SB-1:0];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && has_result) begin
      out_sample_r <= sat;
      out_last_r   <= last_now;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_frame_last = out_last_r;

  // ---------------- checks ----------------
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= w_last_r)
    else $error("column counter past the right border");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= h_last_r)
    else $error("row counter past the bottom border");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && has_result) |=> out_valid_r)
    else $error("interior request left no result");

  // the frame wraps after its last border sample
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && row_r == h_last_r && col_r == w_last_r) |=> (col_r == '0 && row_r == '0))
    else $error("frame did not wrap after its last border sample");

  a_cfg_prime: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_ready)
    else $error("request taken before the window was primed");

endmodule

FILE: verif/five_point_stencil_stream_test.sv
module five_point_stencil_stream_test;
  import fpss_pkg::*;

  localparam int LINE_DEPTH    = DEF_MAX_WIDTH + 2;
  localparam int SB            = DEF_SAMPLE_BITS;
  localparam longint SAT_HI    = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SAT_LO    = -SAT_HI - 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 600;
  localparam int WIDE_ITEMS    = 100;
  localparam int TALL_ITEMS    = 240;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [SB-1:0] sample_out;
    logic                 frame_last;
  } stencil_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [SB-1:0]     in_sample_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [SB-1:0]     out_sample_out;
  logic                     out_frame_last;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Requests waiting for the driver, results waiting for the DUT
  logic [SB-1:0]   samples_to_send[$];
  stencil_result_t stencil_results_due[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  // Stencil state mirror
  logic signed [SB-1:0]     upper_line [0:LINE_DEPTH-1] = '{default: '0};
  logic signed [SB-1:0]     middle_line[0:LINE_DEPTH-1] = '{default: '0};
  logic signed [SB-1:0]     west_sample = '0;
  logic [CFG_DIM_BITS-1:0]  width_raw = DIM_RESET;
  logic [CFG_DIM_BITS-1:0]  height_raw = DIM_RESET;
  int unsigned              col_pos = 0;
  int unsigned              row_pos = 0;

  five_point_stencil_stream u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Zero counts as one, oversize clamps
  function automatic int unsigned size_limit(input logic [CFG_DIM_BITS-1:0] raw,
                                             input int unsigned maxv);
    if (raw == 0) return 1;
    if (raw > maxv) return maxv;
    return raw;
  endfunction

  function automatic int unsigned frame_len();
    return (size_limit(width_raw, DEF_MAX_WIDTH) + 2) *
           (size_limit(height_raw, DEF_MAX_HEIGHT) + 2);
  endfunction

  // One raster step of the stencil: shift the column, maybe emit a result
  task automatic stencil_step(input logic signed [SB-1:0] south, output bit emits,
                              output stencil_result_t res);
    int unsigned          w, h, c, r;
    logic signed [SB-1:0] north, center, east;
    longint               sum, q;
    w = size_limit(width_raw, DEF_MAX_WIDTH);
    h = size_limit(height_raw, DEF_MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    emits = 1'b0;
    res = '0;
    if (c > w + 1) c = 0;
    if (r > h + 1) r = 0;
    north = upper_line[c];
    center = middle_line[c];
    if (r >= 2 && c >= 1 && c <= w) begin
      east = middle_line[c + 1];
      sum = 3 * longint'(center) + longint'(north) + longint'(south) +
            longint'(west_sample) + longint'(east);
      q = sum >>> 2;
      if (q > SAT_HI) q = SAT_HI;
      else if (q < SAT_LO) q = SAT_LO;
      res.sample_out = q[SB-1:0];
      res.frame_last = (r == h + 1 && c == w);
      emits = 1'b1;
    end
    upper_line[c] = center;
    middle_line[c] = south;
    west_sample = center;
    if (c >= w + 1) begin
      c = 0;
      r = (r >= h + 1) ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // Mix of full-range, small, and extreme samples
  function automatic logic [SB-1:0] random_sample();
    logic [19:0] lo;
    lo = 20'($urandom());
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {{(SB - 20){lo[19]}}, lo};
      2: return $urandom_range(0, 1) ? {1'b0, {(SB - 1){1'b1}}} : {1'b1, {(SB - 1){1'b0}}};
      default: return $urandom() | (32'h1 << (SB - 2));
    endcase
  endfunction

  function automatic logic [CFG_DIM_BITS-1:0] pick_size(input int unsigned top);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_DIM_BITS'($urandom_range(9, top));
      default: return CFG_DIM_BITS'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin send_gap_pct = 47; recv_stall_pct = 0; end
      IDLE_RECV: begin send_gap_pct = 0; recv_stall_pct = 47; end
      IDLE_BOTH: begin send_gap_pct = 29; recv_stall_pct = 29; end
      default:   begin send_gap_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // APB write: setup, then access; counters restart in the mirror
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_raw = data[CFG_DIM_BITS-1:0];
    else height_raw = data[CFG_DIM_BITS-1:0];
    col_pos = 0;
    row_pos = 0;
    @(negedge clk);
  endtask

  task automatic push_samples(input int unsigned count);
    repeat (count) samples_to_send.push_back(random_sample());
  endtask

  // Wait until every request is taken and every result is back
  task automatic drain_and_settle();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || stencil_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_sample_in <= samples_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Predict on each taken request, check each taken result
  always @(posedge clk) begin : scoreboard
    stencil_result_t fresh, oldest;
    bit              emits;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        stencil_step(in_sample_in, emits, fresh);
        if (emits) stencil_results_due.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        if (stencil_results_due.size() == 0) begin
          $error("unexpected result: sample_out %0d frame_last %0b",
                 out_sample_out, out_frame_last);
          mismatch_count++;
        end else begin
          oldest = stencil_results_due.pop_front();
          if (out_sample_out !== oldest.sample_out) begin
            $error("sample_out: expected %0d, actual %0d", oldest.sample_out, out_sample_out);
            mismatch_count++;
          end
          if (out_frame_last !== oldest.frame_last) begin
            $error("frame_last: expected %0b, actual %0b", oldest.frame_last, out_frame_last);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any request or result moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned             random_items, phase, frames, partial;
    logic [CFG_DIM_BITS-1:0] wsize, hsize;
    random_items = 0;
    phase = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 1x1 frames, saturate high, floor of a small negative sum
    set_idle(IDLE_NONE);
    write_reg(REG_FRAME_WIDTH, 32'd1);
    write_reg(REG_FRAME_HEIGHT, 32'd1);
    repeat (9) samples_to_send.push_back({1'b0, {(SB - 1){1'b1}}});
    for (int i = 0; i < 9; i++) samples_to_send.push_back(i == 4 ? '1 : '0);
    // partial frame, cut short by the next register write
    push_samples(4);
    drain_and_settle();

    // Random phases over small frames, idle pattern rotating
    while (random_items < RANDOM_ITEMS) begin
      set_idle(idle_mode_t'(phase % 4));
      wsize = (phase == 0) ? '0 : pick_size(40);
      hsize = (phase == 0) ? '0 : pick_size(12);
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        write_reg(REG_FRAME_WIDTH, {19'($urandom()), wsize});
        write_reg(REG_FRAME_HEIGHT, {19'($urandom()), hsize});
      end else if ($urandom_range(0, 1)) begin
        write_reg(REG_FRAME_WIDTH, {19'($urandom()), wsize});
      end else begin
        write_reg(REG_FRAME_HEIGHT, {19'($urandom()), hsize});
      end
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        push_samples(frame_len());
        random_items += frame_len();
        // hold off the sender until all results are back
        if (phase % 3 == 1 && f == 0) drain_and_settle();
      end
      if ($urandom_range(0, 1)) begin
        partial = $urandom_range(1, frame_len() - 1);
        push_samples(partial);
        random_items += partial;
      end
      drain_and_settle();
      phase++;
    end

    // Oversize width clamps to the maximum, so no row ends within the burst
    set_idle(IDLE_BOTH);
    write_reg(REG_FRAME_WIDTH, 32'h0000_1FFF);
    write_reg(REG_FRAME_HEIGHT, 32'd1);
    push_samples(WIDE_ITEMS);
    drain_and_settle();

    // Narrow frame with oversize height, cut short long before its last row
    set_idle(IDLE_NONE);
    write_reg(REG_FRAME_WIDTH, 32'd1);
    write_reg(REG_FRAME_HEIGHT, 32'h0000_1FFF);
    push_samples(TALL_ITEMS);
    drain_and_settle();

    if (mismatch_count == 0 && stencil_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
